FILE: rtl/archive_path_safety_checker_assert.svh
// Assertion macros for the archive path safety checker.
// Included by modules that check their own logic; depends on nothing.
`ifndef ARCHIVE_PATH_SAFETY_CHECKER_ASSERT_SVH
`define ARCHIVE_PATH_SAFETY_CHECKER_ASSERT_SVH
`ifndef SYNTHESIS
// A property that must hold at every clock edge outside reset.
`define APSC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// When the antecedent holds, the consequent must hold at the next clock edge.
`define APSC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define APSC_ASSERT(lbl, prop, msg)
`define APSC_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

FILE: rtl/apsc_pkg.sv
// Shared types and constants of the archive path safety checker.
// Used by apsc_path_eval and archive_path_safety_checker; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package apsc_pkg;

  typedef enum logic [3:0] {
    FaultNone      = 4'd0,
    FaultEmpty     = 4'd1,
    FaultTooLong   = 4'd2,
    FaultLeadSlash = 4'd3,
    FaultBadChar   = 4'd4,
    FaultBadUtf8   = 4'd5,
    FaultEmptyComp = 4'd6,
    FaultDotComp   = 4'd7,
    FaultTrailDot  = 4'd8,
    FaultReserved  = 4'd9
  } fault_e;

  localparam int unsigned CountWidth = 17;
  localparam logic [CountWidth-1:0] CountTop = {CountWidth{1'b1}};
  localparam logic [15:0] MaxLenReset = 16'd512;
  localparam int unsigned AddrWidth = 3;
  localparam logic RegMaxLen = 1'b0;

  // Running state of the path that is being received.
  typedef struct packed {
    logic [CountWidth-1:0] byte_count;
    logic [1:0]            utf8_pending;
    logic [2:0]            utf8_lead_len;
    logic [20:0]           code_point;
    fault_e                path_fault;
    fault_e                comp_fault;
    logic [2:0]            comp_length;
    logic                  comp_all_dots;
    logic [7:0]            comp_last_char;
    logic [3:0][7:0]       stem_chars;
    logic [2:0]            stem_length;
    logic                  stem_closed;
    logic                  after_slash;
  } state_t;

  typedef struct packed {
    logic   valid;
    logic   safe;
    fault_e code;
  } result_t;

  localparam state_t StateReset = '{
    byte_count:     '0,
    utf8_pending:   '0,
    utf8_lead_len:  '0,
    code_point:     '0,
    path_fault:     FaultNone,
    comp_fault:     FaultNone,
    comp_length:    '0,
    comp_all_dots:  1'b1,
    comp_last_char: '0,
    stem_chars:     '0,
    stem_length:    '0,
    stem_closed:    1'b0,
    after_slash:    1'b0
  };

endpackage

`default_nettype wire

FILE: rtl/archive_path_safety_checker.sv
// Top level of the archive path safety checker: stream ports, APB register,
// input and result registers. Depends on apsc_pkg, apsc_path_eval and the
// assertion header archive_path_safety_checker_assert.svh.
//
//   Channel   Direction  Transaction payload
//   s_axis    in         tdata = path_byte, tlast = final_byte, tuser = empty_path
//   m_axis    out        tdata[0] = path_safe, tdata[4:1] = fault_code
//   apb       in/out     register 0 at byte address 0: max_path_length
//
// One byte is taken in every cycle while s_axis is not stalled. A verdict passes
// through the input register and the decode logic into the result register,
// which drives m_axis. Reset clears the path state and the valid flags
// and sets max_path_length to 512. While a verdict waits on m_axis, other bytes
// still flow; an item that ends a path holds in the input register until the
// result register is free, and s_axis stalls then.
`timescale 1ns / 1ps
`default_nettype none

module archive_path_safety_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Byte stream in.
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [7:0]                    s_axis_tdata,  // [7:0] path_byte
  input  logic                          s_axis_tlast,
  input  logic                          s_axis_tuser,  // [0] empty_path
  // Verdict stream out.
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [7:0]                    m_axis_tdata,  // [0] path_safe, [4:1] fault_code
  // Configuration port.
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [apsc_pkg::AddrWidth-1:0] paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);

  `include "archive_path_safety_checker_assert.svh"

  // Input register.
  logic       in_valid_q;
  logic [7:0] in_byte_q;
  logic       in_last_q;
  logic       in_empty_q;

  // Running path state and the limit register.
  apsc_pkg::state_t state_q;
  apsc_pkg::state_t state_d;
  logic [15:0]      max_len_q;

  // Result register.
  logic             out_valid_q;
  logic             out_safe_q;
  apsc_pkg::fault_e out_code_q;

  apsc_pkg::result_t res;
  logic              in_take;
  logic              advance;
  logic              reg_hit;

  // An item that ends a path moves on only when the result register is free
  // or being emptied in this cycle; other bytes move on at once.
  assign advance = in_valid_q &&
                   (!(in_last_q || in_empty_q) || !out_valid_q || m_axis_tready);
  assign in_take = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = !in_valid_q || advance;

  apsc_path_eval u_eval (
    .state_i   (state_q),
    .byte_i    (in_byte_q),
    .last_i    (in_last_q),
    .empty_i   (in_empty_q),
    .max_len_i (max_len_q),
    .state_o   (state_d),
    .result_o  (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_take) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_byte_q  <= s_axis_tdata;
      in_last_q  <= s_axis_tlast;
      in_empty_q <= s_axis_tuser;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= apsc_pkg::StateReset;
    end else if (advance) begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance && res.valid) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && res.valid) begin
      out_safe_q <= res.safe;
      out_code_q <= res.code;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {3'b000, 4'(out_code_q), out_safe_q};

  // The single register decodes on the word index; the byte offset is ignored.
  assign reg_hit = (paddr[apsc_pkg::AddrWidth-1] == apsc_pkg::RegMaxLen);
  assign pready  = 1'b1;
  assign prdata  = reg_hit ? {16'd0, max_len_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_len_q <= apsc_pkg::MaxLenReset;
    end else if (psel && penable && pwrite && pready && reg_hit) begin
      max_len_q <= pwdata[15:0];
    end
  end

  // A path-ending item that cannot move on stays in the input register.
  `APSC_ASSERT_NEXT(a_stall_holds, in_valid_q && !advance, in_valid_q && $stable(in_byte_q), "input register lost a stalled transaction")
  // An empty-path item always yields the empty-path fault.
  `APSC_ASSERT_NEXT(a_empty_code, advance && in_empty_q, out_valid_q && out_code_q == apsc_pkg::FaultEmpty, "empty path did not report its fault")
  // A safe verdict never carries a fault code.
  `APSC_ASSERT(a_safe_clean, !(out_valid_q && out_safe_q && out_code_q != apsc_pkg::FaultNone), "safe verdict with a fault code")
  // The running state is back at its reset value after every verdict.
  `APSC_ASSERT_NEXT(a_state_cleared, advance && res.valid, state_q == apsc_pkg::StateReset, "path state not cleared after a verdict")

endmodule

`default_nettype wire

FILE: rtl/apsc_path_eval.sv
// Next-state and verdict logic for one path byte of the path checker.
// Depends on apsc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module apsc_path_eval (
  input  apsc_pkg::state_t  state_i,
  input  logic [7:0]        byte_i,
  input  logic              last_i,
  input  logic              empty_i,
  input  logic [15:0]       max_len_i,
  output apsc_pkg::state_t  state_o,
  output apsc_pkg::result_t result_o
);

  function automatic apsc_pkg::fault_e keep_first(apsc_pkg::fault_e cur,
                                                  apsc_pkg::fault_e nxt);
    return (cur == apsc_pkg::FaultNone) ? nxt : cur;
  endfunction

  function automatic logic [7:0] to_lower(logic [7:0] b);
    return (b >= 8'h41 && b <= 8'h5A) ? b + 8'd32 : b;
  endfunction

  function automatic logic stem_reserved(apsc_pkg::state_t st);
    logic [23:0] s3;
    logic        com;
    logic        lpt;
    s3  = {st.stem_chars[0], st.stem_chars[1], st.stem_chars[2]};
    com = (s3 == "com");
    lpt = (s3 == "lpt");
    if (st.stem_length == 3'd3) begin
      return (s3 == "con") || (s3 == "prn") || (s3 == "aux") || (s3 == "nul");
    end
    if (st.stem_length == 3'd4) begin
      return (com || lpt) && st.stem_chars[3] >= 8'h31 && st.stem_chars[3] <= 8'h39;
    end
    return 1'b0;
  endfunction

  // Judge the component that is open now and start a fresh one.
  function automatic apsc_pkg::state_t close_comp(apsc_pkg::state_t st);
    apsc_pkg::state_t r;
    r = st;
    if (st.comp_length == 3'd0) begin
      r.comp_fault = keep_first(st.comp_fault, apsc_pkg::FaultEmptyComp);
    end else if (st.comp_all_dots && st.comp_length <= 3'd2) begin
      r.comp_fault = keep_first(st.comp_fault, apsc_pkg::FaultDotComp);
    end else if (st.comp_last_char == 8'h2E || st.comp_last_char == 8'h20) begin
      r.comp_fault = keep_first(st.comp_fault, apsc_pkg::FaultTrailDot);
    end else if (stem_reserved(st)) begin
      r.comp_fault = keep_first(st.comp_fault, apsc_pkg::FaultReserved);
    end
    r.comp_length    = apsc_pkg::StateReset.comp_length;
    r.comp_all_dots  = apsc_pkg::StateReset.comp_all_dots;
    r.comp_last_char = apsc_pkg::StateReset.comp_last_char;
    r.stem_chars     = apsc_pkg::StateReset.stem_chars;
    r.stem_length    = apsc_pkg::StateReset.stem_length;
    r.stem_closed    = apsc_pkg::StateReset.stem_closed;
    return r;
  endfunction

  apsc_pkg::state_t  s;
  apsc_pkg::result_t res;
  apsc_pkg::fault_e  code;
  logic [20:0]       cp;

  always_comb begin
    s    = state_i;
    res  = '{valid: 1'b0, safe: 1'b0, code: apsc_pkg::FaultNone};
    code = apsc_pkg::FaultNone;
    cp   = {state_i.code_point[14:0], byte_i[5:0]};

    if (empty_i) begin
      s   = apsc_pkg::StateReset;
      res = '{valid: 1'b1, safe: 1'b0, code: apsc_pkg::FaultEmpty};
    end else begin
      if (s.byte_count == '0 && byte_i == 8'h2F) begin
        s.path_fault = keep_first(s.path_fault, apsc_pkg::FaultLeadSlash);
      end
      if (s.byte_count != apsc_pkg::CountTop) begin
        s.byte_count = s.byte_count + 1'b1;
      end
      if (s.byte_count > {1'b0, max_len_i}) begin
        s.path_fault = keep_first(s.path_fault, apsc_pkg::FaultTooLong);
      end
      if (byte_i == 8'h5C || byte_i == 8'h3A || byte_i == 8'h00) begin
        s.path_fault = keep_first(s.path_fault, apsc_pkg::FaultBadChar);
      end

      // UTF-8 decoding.
      if (s.utf8_pending != 2'd0) begin
        if (byte_i[7:6] != 2'b10) begin
          s.path_fault   = keep_first(s.path_fault, apsc_pkg::FaultBadUtf8);
          s.utf8_pending = 2'd0;
        end else begin
          s.code_point   = cp;
          s.utf8_pending = s.utf8_pending - 2'd1;
          if (s.utf8_pending == 2'd0) begin
            if ((s.utf8_lead_len == 3'd3 && cp < 21'h800) ||
                (s.utf8_lead_len == 3'd4 && cp < 21'h10000) ||
                (cp >= 21'hD800 && cp <= 21'hDFFF) ||
                cp > 21'h10FFFF) begin
              s.path_fault = keep_first(s.path_fault, apsc_pkg::FaultBadUtf8);
            end
          end
        end
      end else if (byte_i <= 8'h7F) begin
        s.utf8_lead_len = 3'd1;
        s.code_point    = {13'd0, byte_i};
      end else if (byte_i >= 8'hC2 && byte_i <= 8'hDF) begin
        s.utf8_lead_len = 3'd2;
        s.code_point    = {16'd0, byte_i[4:0]};
        s.utf8_pending  = 2'd1;
      end else if (byte_i >= 8'hE0 && byte_i <= 8'hEF) begin
        s.utf8_lead_len = 3'd3;
        s.code_point    = {17'd0, byte_i[3:0]};
        s.utf8_pending  = 2'd2;
      end else if (byte_i >= 8'hF0 && byte_i <= 8'hF4) begin
        s.utf8_lead_len = 3'd4;
        s.code_point    = {18'd0, byte_i[2:0]};
        s.utf8_pending  = 2'd3;
      end else begin
        s.path_fault = keep_first(s.path_fault, apsc_pkg::FaultBadUtf8);
      end

      // Component tracking.
      if (byte_i == 8'h2F) begin
        s             = close_comp(s);
        s.after_slash = 1'b1;
      end else begin
        if (s.comp_length != 3'd7) begin
          s.comp_length = s.comp_length + 3'd1;
        end
        if (byte_i != 8'h2E) begin
          s.comp_all_dots = 1'b0;
        end
        s.comp_last_char = byte_i;
        if (!s.stem_closed) begin
          if (byte_i == 8'h2E) begin
            s.stem_closed = 1'b1;
          end else begin
            if (s.stem_length < 3'd4) begin
              s.stem_chars[s.stem_length[1:0]] = to_lower(byte_i);
            end
            if (s.stem_length < 3'd5) begin
              s.stem_length = s.stem_length + 3'd1;
            end
          end
        end
        s.after_slash = 1'b0;
      end

      if (last_i) begin
        if (s.utf8_pending != 2'd0) begin
          s.path_fault = keep_first(s.path_fault, apsc_pkg::FaultBadUtf8);
        end
        if (!s.after_slash) begin
          s = close_comp(s);
        end
        code = (s.path_fault != apsc_pkg::FaultNone) ? s.path_fault : s.comp_fault;
        res  = '{valid: 1'b1, safe: (code == apsc_pkg::FaultNone), code: code};
        s    = apsc_pkg::StateReset;
      end
    end
  end

  assign state_o  = s;
  assign result_o = res;

endmodule

`default_nettype wire
